[hdl/tlfdv_pkg.sv]
// ----------------------------------------------------------------------------
// Tape level package
// Shared types, register codes, reset values and unit sizes for the tape level
// block and its serial arithmetic units.
// ----------------------------------------------------------------------------
package tlfdv_pkg;

   // fraction bits of the filter state
   localparam int FRAC_BITS = 8;

   // serial divider: dividend and divisor widths
   localparam int DIV_N     = 36;
   localparam int DIV_D     = 16;
   localparam int DIV_CNT_W = $clog2(DIV_N);

   // serial multiplier: signed multiplicand, unsigned multiplier
   localparam int MUL_A     = 48;
   localparam int MUL_B     = 24;
   localparam int MUL_P     = MUL_A + MUL_B;
   localparam int MUL_CNT_W = $clog2(MUL_B);

   // right shift from gain product down to the filter format
   localparam int SCALE_SHIFT = 30 - FRAC_BITS;

   // configuration register indexes
   localparam logic [2:0] CSR_DIVIDER_RES = 3'd0;
   localparam logic [2:0] CSR_SUPPLY      = 3'd1;
   localparam logic [2:0] CSR_SLOPE       = 3'd2;
   localparam logic [2:0] CSR_INTERCEPT   = 3'd3;
   localparam logic [2:0] CSR_GAIN        = 3'd4;
   localparam logic [2:0] CSR_OFFSET      = 3'd5;
   localparam logic [2:0] CSR_FILT_DEGREE = 3'd6;

   // configuration reset values
   localparam logic [19:0] RST_DIVIDER_RES = 20'd47000;
   localparam logic [15:0] RST_SUPPLY      = 16'd24000;
   localparam logic [31:0] RST_SLOPE       = 32'hFFFF_0000;
   localparam logic [20:0] RST_INTERCEPT   = 21'd30000;
   localparam logic [15:0] RST_GAIN        = 16'd16384;
   localparam logic [15:0] RST_OFFSET      = 16'd0;
   localparam logic [7:0]  RST_FILT_DEGREE = 8'd4;

   // result status codes
   localparam logic [1:0] STATUS_UPDATED     = 2'd0;
   localparam logic [1:0] STATUS_UNUSABLE    = 2'd1;
   localparam logic [1:0] STATUS_OVER_SUPPLY = 2'd2;

   // saturation limits
   localparam logic [23:0]        R_MAX   = 24'hFF_FFFF;
   localparam logic signed [63:0] L_LIMIT = 64'sd70368744177663;

   typedef struct packed {
      logic [15:0] sample_mv;
      logic        sample_ok;
   } req_type;

   typedef struct packed {
      logic signed [23:0] level_mm;
      logic [1:0]         status;
   } rsp_type;

   // handshake back from a serial unit to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

[hdl/tlfdv_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle, MSB first.
// The divisor must be non-zero. Quotient holds after done until next start.
// ----------------------------------------------------------------------------
module tlfdv_div import tlfdv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_N-1:0]     dividend,
   input  logic [DIV_D-1:0]     divisor,
   output logic [DIV_N-1:0]     quotient,
   output unit_status_type      status
);

   logic [DIV_D-1:0]     rem_ff, rem_in;
   logic [DIV_N-1:0]     quo_ff, quo_in;
   logic [DIV_D-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_D:0]       shifted;
   logic [DIV_D:0]       trial;
   logic                 fits;

   // bring down the next dividend bit and try the subtraction
   assign shifted = {rem_ff, quo_ff[DIV_N-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = ~trial[DIV_D];

   // load on start, then shift one quotient bit in per cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DIV_D-1:0] : shifted[DIV_D-1:0];
         quo_in = {quo_ff[DIV_N-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[hdl/tlfdv_mul.sv]
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle,
// LSB first, with the low product bits shifted into the multiplier register.
// ----------------------------------------------------------------------------
module tlfdv_mul import tlfdv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MUL_A-1:0]     mcand,
   input  logic [MUL_B-1:0]     mplier,
   output logic [MUL_P-1:0]     product,
   output unit_status_type      status
);

   logic [MUL_A:0]       acc_ff, acc_in;
   logic [MUL_A-1:0]     mcd_ff, mcd_in;
   logic [MUL_B-1:0]     mpl_ff, mpl_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_A+1:0]     addend;
   logic [MUL_A+1:0]     sum;

   // add the multiplicand when the current multiplier bit is set
   assign addend = mpl_ff[0] ? {{2{mcd_ff[MUL_A-1]}}, mcd_ff} : '0;
   assign sum    = {acc_ff[MUL_A], acc_ff} + addend;

   // load on start, then add and shift right once per cycle
   always_comb begin
      acc_in  = acc_ff;
      mcd_in  = mcd_ff;
      mpl_in  = mpl_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mcd_in  = mcand;
         mpl_in  = mplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum[MUL_A+1:1];
         mpl_in = {sum[0], mpl_ff[MUL_B-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcd_ff <= mcd_in;
      mpl_ff <= mpl_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product     = {acc_ff[MUL_A-1:0], mpl_ff};
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[hdl/tape_level_from_divider_voltage.sv]
// ----------------------------------------------------------------------------
// Tape level from divider voltage
// Divider sample to sensor resistance, linear level map, gain and offset,
// then a first-order low-pass filter with a status per transaction.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_*     in         req_valid/req_stall  req_type: sample_mv, sample_ok
//  rsp_*     out        rsp_valid/rsp_stall  rsp_type: level_mm, status
//  csr_*     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A usable sample runs one serial divider (36 steps) twice, for the resistance
// and for the filter step, and one serial multiplier (24 steps) twice, for the
// slope and for the gain. A held sample (unusable or at or above supply) skips
// the serial units and goes straight to the output step. One transaction is
// worked on at a time; the next is taken while a result waits in the output
// register. Reset clears the filter state and the configuration to its defaults.
// ----------------------------------------------------------------------------
module tape_level_from_divider_voltage import tlfdv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0_0000_0000_0001,
      ST_START_R = 13'b0_0000_0000_0010,
      ST_DIV_R   = 13'b0_0000_0000_0100,
      ST_START_L = 13'b0_0000_0000_1000,
      ST_MUL_L   = 13'b0_0000_0001_0000,
      ST_START_G = 13'b0_0000_0010_0000,
      ST_MUL_G   = 13'b0_0000_0100_0000,
      ST_SCALE   = 13'b0_0000_1000_0000,
      ST_DIFF    = 13'b0_0001_0000_0000,
      ST_START_F = 13'b0_0010_0000_0000,
      ST_DIV_F   = 13'b0_0100_0000_0000,
      ST_UPDATE  = 13'b0_1000_0000_0000,
      ST_EMIT    = 13'b1_0000_0000_0000
   } state_type;

   state_type          state_ff, state_in;

   // configuration
   logic [19:0]        rk_ff, rk_in;
   logic [15:0]        supply_ff, supply_in;
   logic [31:0]        slope_ff, slope_in;
   logic [20:0]        icpt_ff, icpt_in;
   logic [15:0]        gain_ff, gain_in;
   logic [15:0]        offset_ff, offset_in;
   logic [7:0]         degree_ff, degree_in;

   // datapath
   logic [DIV_N-1:0]   num_ff, num_in;
   logic [DIV_D-1:0]   den_ff, den_in;
   logic signed [63:0] work_ff, work_in;
   logic               neg_ff, neg_in;
   logic [1:0]         stat_ff, stat_in;
   logic signed [31:0] filt_ff, filt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // serial units
   logic               div_start;
   logic [DIV_N-1:0]   div_dividend;
   logic [DIV_D-1:0]   div_divisor;
   logic [DIV_N-1:0]   div_quo;
   unit_status_type    div_st;
   logic               mul_start;
   logic [MUL_A-1:0]   mul_mcand;
   logic [MUL_B-1:0]   mul_mplier;
   logic [MUL_P-1:0]   mul_prod;
   unit_status_type    mul_st;

   // helpers
   logic               accept;
   logic               slot_free;
   logic [23:0]        r_sat;
   logic signed [63:0] lvl_clamp;
   logic signed [63:0] scaled;
   logic [31:0]        v_clamp;
   logic [32:0]        diff;
   logic [32:0]        diff_mag;
   logic [8:0]         degree_p1;
   logic signed [31:0] filt_int;
   logic [23:0]        level;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // saturate resistance to 24 bits
   assign r_sat = (div_quo[DIV_N-1:24] != '0) ? R_MAX : div_quo[23:0];

   // clamp level to the Q31.16 range before the gain
   always_comb begin
      if (work_ff > L_LIMIT) begin
         lvl_clamp = L_LIMIT;
      end else if (work_ff < -L_LIMIT) begin
         lvl_clamp = -L_LIMIT;
      end else begin
         lvl_clamp = work_ff;
      end
   end

   // scale down to the filter format and clamp to 32 bits
   assign scaled = work_ff >>> SCALE_SHIFT;
   always_comb begin
      if (scaled > 64'sd2147483647) begin
         v_clamp = 32'h7FFF_FFFF;
      end else if (scaled < -64'sd2147483648) begin
         v_clamp = 32'h8000_0000;
      end else begin
         v_clamp = scaled[31:0];
      end
   end

   // filter difference and its magnitude
   assign diff      = {work_ff[31], work_ff[31:0]} - {filt_ff[31], filt_ff};
   assign diff_mag  = work_ff[32] ? (33'd0 - work_ff[32:0]) : work_ff[32:0];
   assign degree_p1 = {1'b0, degree_ff} + 9'd1;

   // integer part of the filter state, saturated to the result width
   assign filt_int = filt_ff >>> FRAC_BITS;
   always_comb begin
      if (filt_int > 32'sd8388607) begin
         level = 24'h7F_FFFF;
      end else if (filt_int < -32'sd8388608) begin
         level = 24'h80_0000;
      end else begin
         level = filt_int[23:0];
      end
   end

   // drive the shared divider
   always_comb begin
      div_start    = 1'b0;
      div_dividend = num_ff;
      div_divisor  = den_ff;
      if (state_ff == ST_START_R) begin
         div_start = 1'b1;
      end else if (state_ff == ST_START_F) begin
         div_start    = 1'b1;
         div_dividend = {{(DIV_N - 33){1'b0}}, diff_mag};
         div_divisor  = {{(DIV_D - 9){1'b0}}, degree_p1};
      end
   end

   // drive the shared multiplier
   always_comb begin
      mul_start  = 1'b0;
      mul_mcand  = {{(MUL_A - 32){slope_ff[31]}}, slope_ff};
      mul_mplier = r_sat;
      if (state_ff == ST_START_L) begin
         mul_start = 1'b1;
      end else if (state_ff == ST_START_G) begin
         mul_start  = 1'b1;
         mul_mcand  = lvl_clamp[MUL_A-1:0];
         mul_mplier = {{(MUL_B - 16){1'b0}}, gain_ff};
      end
   end

   tlfdv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .status   (div_st)
   );

   tlfdv_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .product (mul_prod),
      .status  (mul_st)
   );

   // configuration writes
   always_comb begin
      rk_in     = rk_ff;
      supply_in = supply_ff;
      slope_in  = slope_ff;
      icpt_in   = icpt_ff;
      gain_in   = gain_ff;
      offset_in = offset_ff;
      degree_in = degree_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIVIDER_RES: rk_in     = csr_wdata[19:0];
            CSR_SUPPLY:      supply_in = csr_wdata[15:0];
            CSR_SLOPE:       slope_in  = csr_wdata;
            CSR_INTERCEPT:   icpt_in   = csr_wdata[20:0];
            CSR_GAIN:        gain_in   = csr_wdata[15:0];
            CSR_OFFSET:      offset_in = csr_wdata[15:0];
            CSR_FILT_DEGREE: degree_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sequence one transaction through the serial units
   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      work_in      = work_ff;
      neg_in       = neg_ff;
      stat_in      = stat_ff;
      filt_in      = filt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_data.sample_ok) begin
                  stat_in  = STATUS_UNUSABLE;
                  state_in = ST_EMIT;
               end else if (req_data.sample_mv >= supply_ff) begin
                  stat_in  = STATUS_OVER_SUPPLY;
                  state_in = ST_EMIT;
               end else begin
                  stat_in  = STATUS_UPDATED;
                  num_in   = DIV_N'(req_data.sample_mv) * DIV_N'(rk_ff);
                  den_in   = supply_ff - req_data.sample_mv;
                  state_in = ST_START_R;
               end
            end
         end
         ST_START_R: state_in = ST_DIV_R;
         ST_DIV_R: begin
            if (div_st.done) begin
               state_in = ST_START_L;
            end
         end
         ST_START_L: state_in = ST_MUL_L;
         ST_MUL_L: begin
            // level in Q48.16: slope * R + intercept
            if (mul_st.done) begin
               work_in  = {{8{mul_prod[55]}}, mul_prod[55:0]}
                        + {{27{icpt_ff[20]}}, icpt_ff, 16'b0};
               state_in = ST_START_G;
            end
         end
         ST_START_G: state_in = ST_MUL_G;
         ST_MUL_G: begin
            // gain product less the offset, both in Q.30
            if (mul_st.done) begin
               work_in  = mul_prod[63:0] - {18'b0, offset_ff, 30'b0};
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            work_in  = {{32{v_clamp[31]}}, v_clamp};
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            work_in  = {{31{diff[32]}}, diff};
            state_in = ST_START_F;
         end
         ST_START_F: begin
            neg_in   = work_ff[32];
            state_in = ST_DIV_F;
         end
         ST_DIV_F: begin
            if (div_st.done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // quotient truncates toward zero, so apply its sign afterwards
            filt_in  = neg_ff ? (filt_ff - div_quo[31:0]) : (filt_ff + div_quo[31:0]);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.level_mm = level;
               rsp_data_in.status   = stat_ff;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      den_ff      <= den_in;
      work_ff     <= work_in;
      neg_ff      <= neg_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         filt_ff      <= '0;
         rk_ff        <= RST_DIVIDER_RES;
         supply_ff    <= RST_SUPPLY;
         slope_ff     <= RST_SLOPE;
         icpt_ff      <= RST_INTERCEPT;
         gain_ff      <= RST_GAIN;
         offset_ff    <= RST_OFFSET;
         degree_ff    <= RST_FILT_DEGREE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         filt_ff      <= filt_in;
         rk_ff        <= rk_in;
         supply_ff    <= supply_in;
         slope_ff     <= slope_in;
         icpt_ff      <= icpt_in;
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         degree_ff    <= degree_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // the divider and the multiplier never run at the same time
   assert property (@(posedge clock) disable iff (reset)
      !(div_st.busy && mul_st.busy))
      else $error("divider and multiplier busy together");

   // waiting on the divider means it is running or has just finished
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_R || state_ff == ST_DIV_F) |-> (div_st.busy || div_st.done))
      else $error("waiting on an idle divider");

   // waiting on the multiplier means it is running or has just finished
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_L || state_ff == ST_MUL_G) |-> (mul_st.busy || mul_st.done))
      else $error("waiting on an idle multiplier");

   // the filter state moves only in the update step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_UPDATE) |=> $stable(filt_ff))
      else $error("filter state changed outside update");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape level testbench
// Drives divider samples through the block across several register settings
// and idle patterns. A local model predicts each filtered level and status,
// and every response is checked in order against it.
// ----------------------------------------------------------------------------
module testbench;
   import tlfdv_pkg::*;

   // index with no register behind it, writes there must be ignored
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   localparam longint INT32_LO = -64'sd2147483648;
   localparam longint INT32_HI = 64'sd2147483647;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_DIVIDER_RES;
   logic [31:0] csr_wdata = '0;

   // local copy of the register file and the filter state
   logic [19:0]        cfg_divider   = RST_DIVIDER_RES;
   logic [15:0]        cfg_supply    = RST_SUPPLY;
   logic signed [31:0] cfg_slope     = RST_SLOPE;
   logic signed [20:0] cfg_intercept = RST_INTERCEPT;
   logic [15:0]        cfg_gain      = RST_GAIN;
   logic [15:0]        cfg_offset    = RST_OFFSET;
   logic [7:0]         cfg_degree    = RST_FILT_DEGREE;
   logic signed [31:0] filter_state  = '0;

   req_type pending_samples[$];
   rsp_type expected_levels[$];
   rsp_type oldest_level;

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   logic req_taken = 1'b0;
   int  mismatch_count = 0;

   tape_level_from_divider_voltage uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // work out the level for one accepted sample and advance the filter
   function automatic rsp_type predict_level(req_type item);
      longint  res;
      longint  lvl;
      longint  v;
      longint  diff;
      rsp_type result;
      result.status = STATUS_UPDATED;
      if (!item.sample_ok) begin
         result.status = STATUS_UNUSABLE;
      end else if (item.sample_mv >= cfg_supply) begin
         result.status = STATUS_OVER_SUPPLY;
      end else begin
         res = longint'(item.sample_mv) * longint'(cfg_divider) /
               longint'(cfg_supply - item.sample_mv);
         if (res > longint'(R_MAX)) res = longint'(R_MAX);
         lvl = longint'(cfg_slope) * res + longint'(cfg_intercept) * 65536;
         if (lvl > L_LIMIT) lvl = L_LIMIT;
         if (lvl < -L_LIMIT) lvl = -L_LIMIT;
         v = (lvl * longint'(cfg_gain)) >>> 14;
         v = v - longint'(cfg_offset) * 65536;
         v = v >>> (16 - FRAC_BITS);
         if (v > INT32_HI) v = INT32_HI;
         if (v < INT32_LO) v = INT32_LO;
         // division truncates toward zero on signed operands
         diff = v - longint'(filter_state);
         filter_state = 32'(longint'(filter_state) + diff / (longint'(cfg_degree) + 1));
      end
      result.level_mm = 24'(filter_state >>> FRAC_BITS);
      return result;
   endfunction

   // one register write, mirrored into the local copy once accepted
   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DIVIDER_RES: cfg_divider   = data[19:0];
         CSR_SUPPLY:      cfg_supply    = data[15:0];
         CSR_SLOPE:       cfg_slope     = data;
         CSR_INTERCEPT:   cfg_intercept = data[20:0];
         CSR_GAIN:        cfg_gain      = data[15:0];
         CSR_OFFSET:      cfg_offset    = data[15:0];
         CSR_FILT_DEGREE: cfg_degree    = data[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_sample(int mv, bit ok);
      req_type item;
      item.sample_mv = 16'(mv);
      item.sample_ok = ok;
      pending_samples.push_back(item);
   endtask

   // mostly samples below supply, some near it and some anywhere
   task automatic push_random_samples(int count);
      int pick;
      int mv;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 75 && cfg_supply > 0)
            mv = $urandom_range(0, cfg_supply - 1);
         else if (pick < 87)
            mv = int'(cfg_supply) + $urandom_range(0, 6) - 3;
         else
            mv = $urandom_range(0, 65535);
         push_sample(mv, $urandom_range(0, 99) < 88);
      end
   endtask

   task automatic randomise_config();
      write_csr(CSR_DIVIDER_RES, $urandom_range(1, 1000000));
      write_csr(CSR_SUPPLY, $urandom_range(1, 65535));
      if ($urandom_range(0, 1))
         write_csr(CSR_SLOPE, $urandom_range(0, 1048576) - 524288);
      else
         write_csr(CSR_SLOPE, $urandom);
      write_csr(CSR_INTERCEPT, $urandom_range(0, 2000000) - 1000000);
      write_csr(CSR_GAIN, $urandom_range(0, 65535));
      write_csr(CSR_OFFSET, $urandom_range(0, 50000));
      if ($urandom_range(0, 1))
         write_csr(CSR_FILT_DEGREE, $urandom_range(0, 8));
      else
         write_csr(CSR_FILT_DEGREE, $urandom_range(0, 255));
   endtask

   task automatic set_idle_mode(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
         default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
   endtask

   // hold until every sample is sent and every response is back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_levels.size() != 0);
   endtask

   // driver: present the next sample once the previous one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_stall_pct);
   end

   // monitor: check responses in order, predict each accepted sample
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response: level %0d status %0d",
                           rsp_data.level_mm, rsp_data.status);
               mismatch_count++;
            end else begin
               oldest_level = expected_levels.pop_front();
               if (rsp_data.level_mm !== oldest_level.level_mm ||
                   rsp_data.status !== oldest_level.status) begin
                  if (mismatch_count < 10)
                     $display("mismatch: level exp %0d got %0d, status exp %0d got %0d",
                              oldest_level.level_mm, rsp_data.level_mm,
                              oldest_level.status, rsp_data.status);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_levels.push_back(predict_level(req_data));
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: edges of the sample range and the held cases
      set_idle_mode(0);
      push_sample(0, 1);
      push_sample(1, 1);
      push_sample(12000, 1);
      push_sample(23999, 1);
      push_sample(24000, 1);
      push_sample(24001, 1);
      push_sample(65535, 1);
      push_sample(5000, 0);
      push_sample(65535, 0);
      push_sample(0, 0);
      push_sample(12000, 1);
      push_sample(6000, 1);
      wait_drained();

      // upper extremes, no filtering, resistance saturates
      set_idle_mode(1);
      write_csr(CSR_DIVIDER_RES, 1000000);
      write_csr(CSR_SUPPLY, 65535);
      write_csr(CSR_SLOPE, 32'h7FFF_FFFF);
      write_csr(CSR_INTERCEPT, 1000000);
      write_csr(CSR_GAIN, 65535);
      write_csr(CSR_OFFSET, 0);
      write_csr(CSR_FILT_DEGREE, 0);
      push_sample(65534, 1);
      push_sample(65535, 1);
      push_sample(0, 1);
      push_sample(1, 1);
      push_sample(32768, 1);
      push_random_samples(50);
      wait_drained();

      // lower extremes, heaviest filtering
      set_idle_mode(2);
      write_csr(CSR_DIVIDER_RES, 1);
      write_csr(CSR_SUPPLY, 1);
      write_csr(CSR_SLOPE, 32'h8000_0000);
      write_csr(CSR_INTERCEPT, -1000000);
      write_csr(CSR_GAIN, 0);
      write_csr(CSR_OFFSET, 50000);
      write_csr(CSR_FILT_DEGREE, 255);
      push_sample(0, 1);
      push_sample(1, 1);
      push_sample(0, 0);
      push_random_samples(50);
      wait_drained();

      // zero supply holds everything; unmapped index must not disturb state
      set_idle_mode(3);
      write_csr(CSR_UNUSED, $urandom);
      write_csr(CSR_SUPPLY, 0);
      push_sample(0, 1);
      push_random_samples(25);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         set_idle_mode(phase);
         randomise_config();
         if (phase == 3) write_csr(CSR_UNUSED, $urandom);
         push_random_samples(80);
         wait_drained();
      end

      repeat (150) @(posedge clock);
      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("tape_level_from_divider_voltage test passed");
      end else begin
         $display("tape_level_from_divider_voltage test failed");
      end
      $finish;
   end

   // drop the run if it hangs
   initial begin
      #25_000_000;
      $display("tape_level_from_divider_voltage test failed");
      $finish;
   end

endmodule

[filelist.f]
hdl/tlfdv_pkg.sv
hdl/tlfdv_div.sv
hdl/tlfdv_mul.sv
hdl/tape_level_from_divider_voltage.sv
tb/testbench.sv
